// ===== rtl/msus_pkg.sv =====
// Shared types, codes and constants for the motor spin-up supervisor.
// No dependencies; imported by every module of the block.
package msus_pkg;

    localparam int RPM_W     = 16;
    localparam int RPM_PORTS = 8;
    localparam int MCNT_W    = 4;
    localparam int VCNT_W    = 10;
    localparam int FTMR_W    = 12;
    localparam int RETRY_W   = 3;
    localparam int THR_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [VCNT_W-1:0]  VCNT_MAX  = 10'd1023;
    localparam logic [RETRY_W-1:0] RETRY_SAT = 3'd7;
    localparam logic [THR_W-1:0]   KICK_LOW  = 10'd100;
    localparam logic [THR_W-1:0]   KICK_HIGH = 10'd300;

    // Register reset values
    localparam logic [MCNT_W-1:0]  RST_MOTOR_COUNT = 4'd4;
    localparam logic [RPM_W-1:0]   RST_RPM_LOW     = 16'd1000;
    localparam logic [RPM_W-1:0]   RST_RPM_HIGH    = 16'd50000;
    localparam logic [RPM_W-1:0]   RST_STOP_RPM    = 16'd10;
    localparam logic [VCNT_W-1:0]  RST_VALID_TICKS = 10'd200;
    localparam logic [FTMR_W-1:0]  RST_FAIL_TICKS  = 12'd1000;
    localparam logic [RETRY_W-1:0] RST_MAX_RETRIES = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOTOR_COUNT = 3'd0,
        CFG_RPM_LOW     = 3'd1,
        CFG_RPM_HIGH    = 3'd2,
        CFG_STOP_RPM    = 3'd3,
        CFG_VALID_TICKS = 3'd4,
        CFG_FAIL_TICKS  = 3'd5,
        CFG_MAX_RETRIES = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_SPIN_UP   = 2'd1,
        OP_SPIN_DOWN = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_ZERO     = 3'd1,
        CMD_START    = 3'd2,
        CMD_THROTTLE = 3'd3,
        CMD_RELEASE  = 3'd4,
        CMD_STOP     = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_STARTING = 3'd1,
        ST_RUNNING  = 3'd2,
        ST_STOPPING = 3'd3,
        ST_STOPPED  = 3'd4,
        ST_FAILED   = 3'd5,
        ST_RETRY    = 3'd6
    } status_t;

    // Supervisor mode, one-hot
    typedef enum logic [6:0] {
        MODE_IDLE     = 7'b0000001,
        MODE_STARTING = 7'b0000010,
        MODE_RUNNING  = 7'b0000100,
        MODE_STOPPING = 7'b0001000,
        MODE_STOPPED  = 7'b0010000,
        MODE_FAILED   = 7'b0100000,
        MODE_RETRY    = 7'b1000000
    } mode_t;

    typedef struct packed {
        logic [MCNT_W-1:0]  motor_count;
        logic [RPM_W-1:0]   rpm_low;
        logic [RPM_W-1:0]   rpm_high;
        logic [RPM_W-1:0]   stop_rpm;
        logic [VCNT_W-1:0]  valid_ticks;
        logic [FTMR_W-1:0]  fail_ticks;
        logic [RETRY_W-1:0] max_retries;
    } cfg_t;

    // rpm check results for the sample in the input register
    typedef struct packed {
        logic in_window;
        logic stopped;
    } rpm_flags_t;

    // One request's worth of results: a single command or the start burst
    typedef struct packed {
        logic    burst;
        cmd_t    cmd;
        status_t status;
    } desc_t;

    function automatic status_t mode_to_status(mode_t m);
        status_t s;
        s = ST_IDLE;
        unique case (m)
            MODE_IDLE:     s = ST_IDLE;
            MODE_STARTING: s = ST_STARTING;
            MODE_RUNNING:  s = ST_RUNNING;
            MODE_STOPPING: s = ST_STOPPING;
            MODE_STOPPED:  s = ST_STOPPED;
            MODE_FAILED:   s = ST_FAILED;
            MODE_RETRY:    s = ST_RETRY;
            default:       s = ST_IDLE;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/msus_eval.sv =====
// Parallel rpm window and stop checks over the active motors.
// Depends on msus_pkg.
module msus_eval import msus_pkg::*;
#(
    parameter int MAX_MOTORS = 8
)
(
    input  logic [RPM_PORTS-1:0][RPM_W-1:0] rpm,
    input  cfg_t                            cfg,
    output rpm_flags_t                      flags
);

    localparam logic [MCNT_W-1:0] MAX_CNT = MCNT_W'(MAX_MOTORS);

    logic [MCNT_W-1:0] active;

    // Motor count saturates at the number of supported motors
    assign active = (cfg.motor_count > MAX_CNT) ? MAX_CNT : cfg.motor_count;

    // One comparator pair per motor, ANDed over the active ones
    always_comb
    begin
        flags.in_window = 1'b1;
        flags.stopped   = 1'b1;
        for (int i = 0; i < RPM_PORTS; i++)
        begin
            if (MCNT_W'(i) < active)
            begin
                if ((rpm[i] < cfg.rpm_low) || (rpm[i] > cfg.rpm_high))
                begin
                    flags.in_window = 1'b0;
                end
                if (rpm[i] > cfg.stop_rpm)
                begin
                    flags.stopped = 1'b0;
                end
            end
        end
    end

endmodule

// ===== rtl/msus_ctrl.sv =====
// Input register, supervisor mode and counters, and result descriptor build.
// Depends on msus_pkg and msus_eval.
module msus_ctrl import msus_pkg::*;
#(
    parameter int MAX_MOTORS = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cfg_t                            cfg,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      opcode,
    input  logic [RPM_PORTS-1:0][RPM_W-1:0] rpm,
    input  logic                            desc_free,
    output logic                            desc_push,
    output desc_t                           desc
);

    logic                            s1_valid_reg;
    op_t                             op_reg;
    logic [RPM_PORTS-1:0][RPM_W-1:0] rpm_reg;

    mode_t               mode_reg, mode_next;
    logic [VCNT_W-1:0]   vc_reg, vc_next;
    logic [FTMR_W-1:0]   ft_reg, ft_next;
    logic [RETRY_W-1:0]  rc_reg, rc_next;

    rpm_flags_t          flags;
    logic [VCNT_W-1:0]   vc_inc;
    logic [VCNT_W-1:0]   vc_win;
    logic                begin_att;
    logic                advance;
    logic                accept;

    assign advance   = s1_valid_reg && desc_free;
    assign in_stall  = s1_valid_reg && !desc_free;
    assign accept    = in_valid && !in_stall;
    assign desc_push = advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(opcode);
            rpm_reg <= rpm;
        end
    end

    msus_eval #(
        .MAX_MOTORS (MAX_MOTORS)
    ) u_eval (
        .rpm   (rpm_reg),
        .cfg   (cfg),
        .flags (flags)
    );

    // Next state and descriptor for the request in the input register
    always_comb
    begin
        mode_next = mode_reg;
        vc_next   = vc_reg;
        ft_next   = ft_reg;
        rc_next   = rc_reg;
        begin_att = 1'b0;
        desc.burst = 1'b0;
        desc.cmd   = CMD_NONE;
        vc_inc = (vc_reg == VCNT_MAX) ? vc_reg : vc_reg + 10'd1;
        vc_win = flags.in_window ? vc_inc : '0;

        unique case (op_reg)
            OP_SPIN_UP:
            begin
                rc_next   = '0;
                begin_att = 1'b1;
            end
            OP_SPIN_DOWN:
            begin
                mode_next = MODE_STOPPING;
                desc.cmd  = CMD_STOP;
            end
            OP_TICK:
            begin
                unique case (mode_reg)
                    MODE_STARTING:
                    begin
                        if (ft_reg == '0)
                        begin
                            // attempt timed out
                            vc_next   = vc_inc;
                            rc_next   = (rc_reg == RETRY_SAT) ? rc_reg : rc_reg + 3'd1;
                            mode_next = MODE_RETRY;
                            desc.cmd  = CMD_STOP;
                        end
                        else
                        begin
                            ft_next = ft_reg - 12'd1;
                            vc_next = vc_win;
                            if (vc_win > cfg.valid_ticks)
                            begin
                                mode_next = MODE_RUNNING;
                                desc.cmd  = CMD_RELEASE;
                            end
                        end
                    end
                    MODE_RETRY:
                    begin
                        if (flags.stopped)
                        begin
                            if (rc_reg >= cfg.max_retries)
                            begin
                                mode_next = MODE_FAILED;
                            end
                            else
                            begin
                                begin_att = 1'b1;
                            end
                        end
                    end
                    MODE_STOPPING:
                    begin
                        if (flags.stopped)
                        begin
                            mode_next = MODE_STOPPED;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        // fresh start attempt: counters reloaded, burst of commands
        if (begin_att)
        begin
            mode_next  = MODE_STARTING;
            vc_next    = '0;
            ft_next    = cfg.fail_ticks;
            desc.burst = 1'b1;
            desc.cmd   = CMD_ZERO;
        end
        desc.status = mode_to_status(mode_next);
    end

    // Supervisor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            vc_reg   <= '0;
            ft_reg   <= '0;
            rc_reg   <= '0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            vc_reg   <= vc_next;
            ft_reg   <= ft_next;
            rc_reg   <= rc_next;
        end
    end

    a_spin_up_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (op_reg == OP_SPIN_UP)) |=> (mode_reg == MODE_STARTING))
        else $error("spin-up did not enter starting");

    a_spin_down_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (op_reg == OP_SPIN_DOWN)) |=> (mode_reg == MODE_STOPPING))
        else $error("spin-down did not enter stopping");

    a_running_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (mode_reg == MODE_STARTING) && (mode_next == MODE_RUNNING))
        |=> (vc_reg > cfg.valid_ticks))
        else $error("running reached without enough valid ticks");

endmodule

// ===== rtl/msus_out.sv =====
// Result descriptor register and expander into single result items.
// Depends on msus_pkg.
module msus_out import msus_pkg::*;
#(
    parameter int KICK_PULSES = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             desc_push,
    input  desc_t            desc,
    output logic             desc_free,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       command,
    output logic [THR_W-1:0] throttle_permille,
    output logic [2:0]       status,
    output logic             last
);

    localparam int BURST_LEN = KICK_PULSES + 2;
    localparam int CNT_W     = $clog2(BURST_LEN);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(BURST_LEN - 1);

    logic             desc_valid_reg;
    desc_t            desc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_take;
    cmd_t             cmd_cur;

    assign out_valid = desc_valid_reg;
    assign out_take  = desc_valid_reg && !out_stall;
    assign desc_free = !desc_valid_reg || (out_take && last);

    // Expand the held descriptor at the current burst position
    always_comb
    begin
        cmd_cur           = desc_reg.cmd;
        throttle_permille = '0;
        last              = 1'b1;
        if (desc_reg.burst)
        begin
            last = (cnt_reg == LAST_IDX);
            if (cnt_reg == '0)
            begin
                cmd_cur = CMD_ZERO;
            end
            else if (cnt_reg == CNT_W'(1))
            begin
                cmd_cur = CMD_START;
            end
            else
            begin
                cmd_cur           = CMD_THROTTLE;
                throttle_permille = cnt_reg[0] ? KICK_HIGH : KICK_LOW;
            end
        end
    end

    assign command = cmd_cur;
    assign status  = desc_reg.status;

    // Descriptor valid and burst position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else if (desc_push)
        begin
            desc_valid_reg <= 1'b1;
            cnt_reg        <= '0;
        end
        else if (out_take)
        begin
            if (last)
            begin
                desc_valid_reg <= 1'b0;
                cnt_reg        <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_push)
        begin
            desc_reg <= desc;
        end
    end

    a_burst_is_starting: assert property (@(posedge clk) disable iff (!rst_n)
        (desc_valid_reg && desc_reg.burst) |-> (desc_reg.status == ST_STARTING))
        else $error("start burst with wrong status");

    a_single_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (desc_valid_reg && !desc_reg.burst) |-> (cnt_reg == '0))
        else $error("single result descriptor with nonzero position");

    a_push_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        desc_push |-> desc_free)
        else $error("descriptor overwritten before its last result");

endmodule

// ===== rtl/motor_spin_up_supervisor_top.sv =====
// Top level of the motor spin-up supervisor: configuration registers and
// the control and output stages. Depends on msus_pkg, msus_ctrl, msus_out.
//
// Usage:
//   Input channel (in_valid/in_stall): one request per accepted item; opcode
//   0 is a tick carrying rpm_0..rpm_7, 1 a spin-up, 2 a spin-down.
//   Output channel (out_valid/out_stall): command, throttle_permille, status
//   and last; last marks the final result of a request.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): cfg_ready is
//   always high; write only while no request is in flight.
// Path: a result is presented after its request has passed the input
//   register, then the descriptor register.
// Throughput: one request per cycle while each yields a single result and
//   out_stall is low. A spin-up or retry restart yields KICK_PULSES + 2
//   results from the descriptor register, one per cycle while out_stall is
//   low; a full input register then stalls until the last one is taken.
// Reset: mode idle, counters zero, registers at their defaults, no result
//   pending. When the receiver stalls, the result holds and the input stage
//   stalls once its register is full.
module motor_spin_up_supervisor_top import msus_pkg::*;
#(
    parameter int MAX_MOTORS  = 8,
    parameter int KICK_PULSES = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           opcode,
    input  logic [RPM_W-1:0]     rpm_0,
    input  logic [RPM_W-1:0]     rpm_1,
    input  logic [RPM_W-1:0]     rpm_2,
    input  logic [RPM_W-1:0]     rpm_3,
    input  logic [RPM_W-1:0]     rpm_4,
    input  logic [RPM_W-1:0]     rpm_5,
    input  logic [RPM_W-1:0]     rpm_6,
    input  logic [RPM_W-1:0]     rpm_7,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           command,
    output logic [THR_W-1:0]     throttle_permille,
    output logic [2:0]           status,
    output logic                 last
);

    cfg_t                            cfg_reg;
    logic [RPM_PORTS-1:0][RPM_W-1:0] rpm;
    logic                            desc_free;
    logic                            desc_push;
    desc_t                           desc;

    assign cfg_ready = 1'b1;
    assign rpm = {rpm_7, rpm_6, rpm_5, rpm_4, rpm_3, rpm_2, rpm_1, rpm_0};

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motor_count <= RST_MOTOR_COUNT;
            cfg_reg.rpm_low     <= RST_RPM_LOW;
            cfg_reg.rpm_high    <= RST_RPM_HIGH;
            cfg_reg.stop_rpm    <= RST_STOP_RPM;
            cfg_reg.valid_ticks <= RST_VALID_TICKS;
            cfg_reg.fail_ticks  <= RST_FAIL_TICKS;
            cfg_reg.max_retries <= RST_MAX_RETRIES;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MOTOR_COUNT: cfg_reg.motor_count <= cfg_data[MCNT_W-1:0];
                CFG_RPM_LOW:     cfg_reg.rpm_low     <= cfg_data[RPM_W-1:0];
                CFG_RPM_HIGH:    cfg_reg.rpm_high    <= cfg_data[RPM_W-1:0];
                CFG_STOP_RPM:    cfg_reg.stop_rpm    <= cfg_data[RPM_W-1:0];
                CFG_VALID_TICKS: cfg_reg.valid_ticks <= cfg_data[VCNT_W-1:0];
                CFG_FAIL_TICKS:  cfg_reg.fail_ticks  <= cfg_data[FTMR_W-1:0];
                CFG_MAX_RETRIES: cfg_reg.max_retries <= cfg_data[RETRY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    msus_ctrl #(
        .MAX_MOTORS (MAX_MOTORS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .rpm       (rpm),
        .desc_free (desc_free),
        .desc_push (desc_push),
        .desc      (desc)
    );

    msus_out #(
        .KICK_PULSES (KICK_PULSES)
    ) u_out (
        .clk               (clk),
        .rst_n             (rst_n),
        .desc_push         (desc_push),
        .desc              (desc),
        .desc_free         (desc_free),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .command           (command),
        .throttle_permille (throttle_permille),
        .status            (status),
        .last              (last)
    );

endmodule
